FILE: hw/rtl/usmg_pkg.sv
// Shared constants, types and arithmetic helpers of the UV-sphere mesh generator.
`timescale 1ns / 1ps
package usmg_pkg;

  localparam int MAX_SLICES_DEF    = 256;
  localparam int CORDIC_STAGES_DEF = 16;

  // Long division of an index by n: one integer bit, then fraction bits.
  localparam int DIV_STEPS = 32;
  localparam int QW        = DIV_STEPS + 1;
  localparam int TEX_STEP  = 15;
  localparam int VPH_STEP  = 31;

  // CORDIC datapath widths and constants (Q30 values, phase of 2^32 per turn).
  localparam int CW           = 34;
  localparam int ZW           = 33;
  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [ZW-1:0] EIGHTH_TURN = 33'sd536870912;

  // Register map, selected by paddr[2].
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_SLICES = 1'b1;

  localparam int TDATA_OUT_W = 168;

  typedef struct packed {
    logic        valid;
    logic        action;
    logic [15:0] p;
    logic [8:0]  s;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [31:0] ph_v;
  } div_side_t;

  typedef struct packed {
    logic        valid;
    logic        action;
    logic [15:0] p;
    logic [8:0]  s;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [31:0] ph_u;
    logic [31:0] ph_v;
  } cor_side_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int k);
    logic signed [ZW-1:0] a;
    case (k)
      0:  a = 33'sh020000000;
      1:  a = 33'sh012E4051E;
      2:  a = 33'sh009FB385B;
      3:  a = 33'sh0051111D4;
      4:  a = 33'sh0028B0D43;
      5:  a = 33'sh00145D7E1;
      6:  a = 33'sh000A2F61E;
      7:  a = 33'sh000517C55;
      8:  a = 33'sh00028BE53;
      9:  a = 33'sh000145F2F;
      10: a = 33'sh0000A2F98;
      11: a = 33'sh0000517CC;
      12: a = 33'sh000028BE6;
      13: a = 33'sh0000145F3;
      14: a = 33'sh00000A2FA;
      15: a = 33'sh00000517D;
      16: a = 33'sh0000028BE;
      17: a = 33'sh00000145F;
      18: a = 33'sh000000A30;
      19: a = 33'sh000000518;
      20: a = 33'sh00000028C;
      21: a = 33'sh000000146;
      22: a = 33'sh0000000A3;
      23: a = 33'sh000000051;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Round-to-nearest correction of a quotient: 1 when rem + floor(n/2) >= n.
  function automatic logic round_up(input logic [7:0] rem, input logic [7:0] n);
    logic [8:0] sum;
    sum = {1'b0, rem} + {2'b00, n[7:1]};
    return (sum >= {1'b0, n});
  endfunction

  // Q30 to Q1.15 with half-up rounding, saturated to +-32767.
  function automatic logic signed [15:0] rnd_sat(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [15:0]   r;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32767) r = 16'sd32767;
    else if (t < -34'sd32767) r = -16'sd32767;
    else r = t[15:0];
    return r;
  endfunction

  function automatic logic signed [15:0] mul_q15(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
    logic signed [31:0] m;
    m = (a * b + 32'sd16384) >>> 15;
    return m[15:0];
  endfunction

  function automatic logic [7:0] tan_byte(input logic signed [15:0] t);
    logic [16:0] d;
    logic [24:0] m;
    d = 17'd32768 - 17'({t[15], t});
    m = d * 25'd255 + 25'd32768;
    return m[23:16];
  endfunction

endpackage

FILE: hw/rtl/usmg_div_cell.sv
// One restoring long-division step of the index-over-n divider chain.
`timescale 1ns / 1ps
module usmg_div_cell (
  input  logic                  clk,
  input  logic                  en,
  input  logic [7:0]            n,
  input  logic [7:0]            rem_in,
  input  logic [usmg_pkg::QW-1:0] q_in,
  output logic [7:0]            rem_out,
  output logic [usmg_pkg::QW-1:0] q_out
);
  import usmg_pkg::*;

  logic [8:0] r2;
  logic [8:0] diff;
  logic       ge;

  always_comb begin
    r2   = {rem_in, 1'b0};
    diff = r2 - {1'b0, n};
    ge   = (r2 >= {1'b0, n});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? diff[7:0] : r2[7:0];
      q_out   <= {q_in[QW-2:0], ge};
    end
  end
endmodule

FILE: hw/rtl/usmg_cordic_cell.sv
// One micro-rotation of the pipelined CORDIC rotator.
`timescale 1ns / 1ps
module usmg_cordic_cell #(
  parameter int K = 0
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [usmg_pkg::CW-1:0] x_in,
  input  logic signed [usmg_pkg::CW-1:0] y_in,
  input  logic signed [usmg_pkg::ZW-1:0] z_in,
  output logic signed [usmg_pkg::CW-1:0] x_out,
  output logic signed [usmg_pkg::CW-1:0] y_out,
  output logic signed [usmg_pkg::ZW-1:0] z_out
);
  import usmg_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = atan_turn(K);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  always_comb begin
    dx = y_in >>> K;
    dy = x_in >>> K;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ZW-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ANGLE;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ANGLE;
      end
    end
  end
endmodule

FILE: hw/rtl/uv_sphere_mesh_generator_unit.sv
// Top level of the UV-sphere mesh generator: config registers, cell chains and output stage.
`timescale 1ns / 1ps
// Usage
// Requests arrive on the s_ channel: s_tuser is the action (0 = vertex, 1 = quad),
// s_tdata holds the column and row indices. Results leave on the m_ channel, one
// transfer per result; m_tlast marks the final result of each request.
// A vertex request gives one result carrying position, normal, tangent bytes and
// texture coordinates. A quad request gives six results carrying triangle indices.
// The radius and slice count are written over the APB port while the block is idle.
// A request passes in order through one input register, a chain of 32 divider cells
// forming the exact angle phases, a phase register, one CORDIC cell per stage, three
// post-processing stages and the output register. One request enters per cycle
// unless the chain stalls; a quad holds the output register for its six results,
// so the output channel sets the rate for quad-heavy traffic.
// When the receiver stalls, the whole chain holds and s_tready falls as soon as the
// output register cannot hand its last result on in the same cycle.
// Reset (synchronous, active high) clears every stage's valid flag and the beat
// counter, and returns radius to 1.0 and slice count to 16.
module uv_sphere_mesh_generator_unit #(
  parameter int MAX_SLICES    = usmg_pkg::MAX_SLICES_DEF,
  parameter int CORDIC_STAGES = usmg_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // col [7:0], row [15:8]
  input  logic [15:0] s_tdata,
  // action [0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pos_x [16:0], pos_y [33:17], pos_z [50:34], nrm_x [66:51], nrm_y [82:67],
  // nrm_z [98:83], tan_x [106:99], tan_z [114:107], tex_u [130:115],
  // tex_v [146:131], mesh_index [162:147], zero fill [167:163]
  output logic [usmg_pkg::TDATA_OUT_W-1:0] m_tdata,
  output logic        m_tlast
);
  import usmg_pkg::*;

  typedef struct packed {
    logic               valid;
    logic               action;
    logic [15:0]        p;
    logic [8:0]         s;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic signed [15:0] su;
    logic signed [15:0] cu;
    logic signed [15:0] sv;
    logic signed [15:0] cv;
  } trig_t;

  typedef struct packed {
    logic               valid;
    logic               action;
    logic [15:0]        p;
    logic [8:0]         s;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [15:0] tx;
    logic signed [15:0] tz;
  } norm_t;

  typedef struct packed {
    logic               valid;
    logic               action;
    logic [15:0]        p;
    logic [8:0]         s;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [16:0]        px;
    logic [16:0]        py;
    logic [16:0]        pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [7:0]         tbx;
    logic [7:0]         tbz;
  } res_t;

  // Configuration registers.
  logic [15:0] radius;
  logic [8:0]  slice_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= 16'd256;
      slice_count <= 9'd16;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_RADIUS: radius      <= pwdata[15:0];
        REG_SLICES: slice_count <= pwdata[8:0];
        default:    radius      <= radius;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SLICES) ? {23'd0, slice_count} : {16'd0, radius};

  // Effective slice count s and segment count n = s - 1. The user must change them only
  // while idle, which the block does not enforce; the chain reads them directly at every stage.
  logic [8:0] s_eff;
  logic [7:0] n;

  always_comb begin
    if (slice_count < 9'd2) s_eff = 9'd2;
    else if (slice_count > 9'(MAX_SLICES)) s_eff = 9'(MAX_SLICES);
    else s_eff = slice_count;
  end
  assign n = 8'(s_eff - 9'd1);

  // Pipeline advance: every stage moves when the output register is free or hands
  // its final result on in this cycle.
  logic ov;
  logic ob_last;
  logic adv;

  assign adv      = !ov || (m_tready && ob_last);
  assign s_tready = adv;

  // Input stage: index clamping, quad base index and the integer step of the division.
  logic [7:0]  in_col, in_row;
  logic [7:0]  vi, vj, qi, qj;
  logic [16:0] pbase;

  always_comb begin
    in_col = s_tdata[7:0];
    in_row = s_tdata[15:8];
    vi     = (in_col > n) ? n : in_col;
    vj     = (in_row > n) ? n : in_row;
    qi     = (in_col > n - 8'd1) ? n - 8'd1 : in_col;
    qj     = (in_row > n - 8'd1) ? n - 8'd1 : in_row;
    pbase  = qi * s_eff + {9'd0, qj};
  end

  logic [7:0]    u_rem0, v_rem0;
  logic          u_q0, v_q0;
  div_side_t     ds [0:DIV_STEPS];

  logic [7:0]    u_rem [0:DIV_STEPS];
  logic [QW-1:0] u_q   [0:DIV_STEPS];
  logic [7:0]    v_rem [0:DIV_STEPS];
  logic [QW-1:0] v_q   [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      // An index equal to n gives quotient one with no remainder.
      u_q0   <= (vi == n);
      u_rem0 <= (vi == n) ? 8'd0 : vi;
      v_q0   <= (vj == n);
      v_rem0 <= (vj == n) ? 8'd0 : vj;
    end
  end

  assign u_rem[0] = u_rem0;
  assign u_q[0]   = {{(QW-1){1'b0}}, u_q0};
  assign v_rem[0] = v_rem0;
  assign v_q[0]   = {{(QW-1){1'b0}}, v_q0};

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    usmg_div_cell u_div_u (
      .clk(clk), .en(adv), .n(n),
      .rem_in(u_rem[k-1]), .q_in(u_q[k-1]),
      .rem_out(u_rem[k]), .q_out(u_q[k])
    );
    usmg_div_cell u_div_v (
      .clk(clk), .en(adv), .n(n),
      .rem_in(v_rem[k-1]), .q_in(v_q[k-1]),
      .rem_out(v_rem[k]), .q_out(v_q[k])
    );
  end

  // Texture coordinates are rounded at fifteen fraction bits, the v phase at 31.
  logic [15:0] tex_u_w, tex_v_w;
  logic [31:0] ph_v_w, ph_u_w;

  always_comb begin
    tex_u_w = u_q[TEX_STEP][15:0] + {15'd0, round_up(u_rem[TEX_STEP], n)};
    tex_v_w = v_q[TEX_STEP][15:0] + {15'd0, round_up(v_rem[TEX_STEP], n)};
    ph_v_w  = v_q[VPH_STEP][31:0] + {31'd0, round_up(v_rem[VPH_STEP], n)};
    ph_u_w  = u_q[DIV_STEPS][31:0] + {31'd0, round_up(u_rem[DIV_STEPS], n)};
  end

  always_ff @(posedge clk) begin
    div_side_t ds_next;
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) ds[k].valid <= 1'b0;
    end else if (adv) begin
      ds[0].valid  <= s_tvalid;
      ds[0].action <= s_tuser[0];
      ds[0].p      <= pbase[15:0];
      ds[0].s      <= s_eff;
      ds[0].tex_u  <= '0;
      ds[0].tex_v  <= '0;
      ds[0].ph_v   <= '0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        ds_next = ds[k-1];
        if (k == TEX_STEP + 1) begin
          ds_next.tex_u = tex_u_w;
          ds_next.tex_v = tex_v_w;
        end
        if (k == VPH_STEP + 1) ds_next.ph_v = ph_v_w;
        ds[k] <= ds_next;
      end
    end
  end

  // Phase register and CORDIC chain.
  cor_side_t cs [0:CORDIC_STAGES];

  logic signed [CW-1:0] cux [0:CORDIC_STAGES];
  logic signed [CW-1:0] cuy [0:CORDIC_STAGES];
  logic signed [ZW-1:0] cuz [0:CORDIC_STAGES];
  logic signed [CW-1:0] cvx [0:CORDIC_STAGES];
  logic signed [CW-1:0] cvy [0:CORDIC_STAGES];
  logic signed [ZW-1:0] cvz [0:CORDIC_STAGES];
  logic [31:0]          sh_u, sh_v;

  // Rotating by an eighth of a turn first leaves an offset in [-45, 45) degrees.
  always_comb begin
    sh_u = cs[0].ph_u + 32'h2000_0000;
    sh_v = cs[0].ph_v + 32'h2000_0000;
  end

  assign cux[0] = GAIN_Q30;
  assign cuy[0] = '0;
  assign cuz[0] = $signed({3'b000, sh_u[29:0]}) - EIGHTH_TURN;
  assign cvx[0] = GAIN_Q30;
  assign cvy[0] = '0;
  assign cvz[0] = $signed({3'b000, sh_v[29:0]}) - EIGHTH_TURN;

  for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_cordic
    usmg_cordic_cell #(.K(k - 1)) u_rot_u (
      .clk(clk), .en(adv),
      .x_in(cux[k-1]), .y_in(cuy[k-1]), .z_in(cuz[k-1]),
      .x_out(cux[k]), .y_out(cuy[k]), .z_out(cuz[k])
    );
    usmg_cordic_cell #(.K(k - 1)) u_rot_v (
      .clk(clk), .en(adv),
      .x_in(cvx[k-1]), .y_in(cvy[k-1]), .z_in(cvz[k-1]),
      .x_out(cvx[k]), .y_out(cvy[k]), .z_out(cvz[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= CORDIC_STAGES; k++) cs[k].valid <= 1'b0;
    end else if (adv) begin
      cs[0].valid  <= ds[DIV_STEPS].valid;
      cs[0].action <= ds[DIV_STEPS].action;
      cs[0].p      <= ds[DIV_STEPS].p;
      cs[0].s      <= ds[DIV_STEPS].s;
      cs[0].tex_u  <= ds[DIV_STEPS].tex_u;
      cs[0].tex_v  <= ds[DIV_STEPS].tex_v;
      cs[0].ph_u   <= ph_u_w;
      cs[0].ph_v   <= ds[DIV_STEPS].ph_v;
      for (int k = 1; k <= CORDIC_STAGES; k++) cs[k] <= cs[k-1];
    end
  end

  // Post stage A: rounding, saturation and quadrant restore.
  function automatic void quad_map(input logic [1:0] q,
                                   input logic signed [15:0] x,
                                   input logic signed [15:0] y,
                                   output logic signed [15:0] s,
                                   output logic signed [15:0] c);
    case (q)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  logic signed [15:0] su_w, cu_w, sv_w, cv_w;
  logic [31:0]        shl_u, shl_v;
  trig_t pa;
  norm_t pb;
  res_t  pc;

  always_comb begin
    shl_u = cs[CORDIC_STAGES].ph_u + 32'h2000_0000;
    shl_v = cs[CORDIC_STAGES].ph_v + 32'h2000_0000;
    quad_map(shl_u[31:30], rnd_sat(cux[CORDIC_STAGES]), rnd_sat(cuy[CORDIC_STAGES]),
             su_w, cu_w);
    quad_map(shl_v[31:30], rnd_sat(cvx[CORDIC_STAGES]), rnd_sat(cvy[CORDIC_STAGES]),
             sv_w, cv_w);
  end

  // Post stage B: normal and tangent selection.
  logic signed [15:0] nx_w, nz_w, tx_w, tz_w;

  always_comb begin
    nx_w = mul_q15(pa.sv, pa.cu);
    nz_w = -mul_q15(pa.sv, pa.su);
    // Away from the poles the tangent is the normalised longitude direction.
    if (pa.sv > 16'sd32) begin
      tx_w = -pa.su;
      tz_w = -pa.cu;
    end else if (pa.sv < -16'sd32) begin
      tx_w = pa.su;
      tz_w = pa.cu;
    end else begin
      tx_w = nz_w;
      tz_w = -nx_w;
    end
  end

  // Post stage C: scaled position and tangent bytes.
  logic signed [16:0] rad_s;
  logic signed [32:0] mpx, mpy, mpz;

  always_comb begin
    rad_s = $signed({1'b0, radius});
    mpx   = (rad_s * pb.nx + 33'sd16384) >>> 15;
    mpy   = (rad_s * pb.ny + 33'sd16384) >>> 15;
    mpz   = (rad_s * pb.nz + 33'sd16384) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pa.valid <= 1'b0;
      pb.valid <= 1'b0;
      pc.valid <= 1'b0;
    end else if (adv) begin
      pa.valid  <= cs[CORDIC_STAGES].valid;
      pa.action <= cs[CORDIC_STAGES].action;
      pa.p      <= cs[CORDIC_STAGES].p;
      pa.s      <= cs[CORDIC_STAGES].s;
      pa.tex_u  <= cs[CORDIC_STAGES].tex_u;
      pa.tex_v  <= cs[CORDIC_STAGES].tex_v;
      pa.su     <= su_w;
      pa.cu     <= cu_w;
      pa.sv     <= sv_w;
      pa.cv     <= cv_w;

      pb.valid  <= pa.valid;
      pb.action <= pa.action;
      pb.p      <= pa.p;
      pb.s      <= pa.s;
      pb.tex_u  <= pa.tex_u;
      pb.tex_v  <= pa.tex_v;
      pb.nx     <= nx_w;
      pb.ny     <= -pa.cv;
      pb.nz     <= nz_w;
      pb.tx     <= tx_w;
      pb.tz     <= tz_w;

      pc.valid  <= pb.valid;
      pc.action <= pb.action;
      pc.p      <= pb.p;
      pc.s      <= pb.s;
      pc.tex_u  <= pb.tex_u;
      pc.tex_v  <= pb.tex_v;
      pc.px     <= mpx[16:0];
      pc.py     <= mpy[16:0];
      pc.pz     <= mpz[16:0];
      pc.nx     <= pb.nx;
      pc.ny     <= pb.ny;
      pc.nz     <= pb.nz;
      pc.tbx    <= tan_byte(pb.tx);
      pc.tbz    <= tan_byte(pb.tz);
    end
  end

  // Output register. A quad stays here for six beats, stepping through its indices.
  res_t       ob;
  logic [2:0] beat;
  logic [15:0] mesh_w;

  assign ob_last = !ob.action || (beat == 3'd5);

  always_ff @(posedge clk) begin
    if (rst) begin
      ov   <= 1'b0;
      beat <= 3'd0;
    end else begin
      if (m_tvalid && m_tready) beat <= ob_last ? 3'd0 : beat + 3'd1;
      if (adv) ov <= pc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) ob <= pc;
  end

  always_comb begin
    case (beat)
      3'd0:    mesh_w = ob.p;
      3'd1:    mesh_w = ob.p + {7'd0, ob.s};
      3'd2:    mesh_w = ob.p + {7'd0, ob.s} + 16'd1;
      3'd3:    mesh_w = ob.p;
      3'd4:    mesh_w = ob.p + {7'd0, ob.s} + 16'd1;
      3'd5:    mesh_w = ob.p + 16'd1;
      default: mesh_w = ob.p;
    endcase
  end

  assign m_tvalid = ov;
  assign m_tlast  = ob_last;

  always_comb begin
    if (ob.action) begin
      m_tdata = {5'd0, mesh_w, 147'd0};
    end else begin
      m_tdata = {5'd0, 16'd0, ob.tex_v, ob.tex_u, ob.tbz, ob.tbx,
                 ob.nz, ob.ny, ob.nx, ob.pz, ob.py, ob.px};
    end
  end

  // An empty output register never holds the chain back.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !ov |-> s_tready)
    else $error("chain stalled with an empty output register");

  // The quad beat counter stays within its six results.
  a_beat_range: assert property (@(posedge clk) disable iff (rst)
    beat <= 3'd5)
    else $error("quad beat counter out of range");

  // A vertex result is always a single, final transfer.
  a_vertex_last: assert property (@(posedge clk) disable iff (rst)
    (ov && !ob.action) |-> (m_tlast && beat == 3'd0))
    else $error("vertex result not marked last");

  // Handing on a final result frees the chain in the same cycle.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |-> s_tready)
    else $error("final transfer did not release the chain");

  // Without a final transfer a busy output register keeps its beat or advances it by one.
  a_beat_step: assert property (@(posedge clk) disable iff (rst)
    (ov && !(m_tready && ob_last)) |=> (ov && (beat == $past(beat) ||
                                               beat == $past(beat) + 3'd1)))
    else $error("output register lost its result");
endmodule

FILE: bench/usmg_checker.sv
// Scoreboard for the UV-sphere mesh generator: predicts every result and compares it.
`timescale 1ns / 1ps
module usmg_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [15:0]  s_tdata,
  input  logic [0:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [167:0] m_tdata,
  input  logic         m_tlast,
  output int           fail_count,
  output int           beats_pending
);
  import usmg_pkg::*;

  typedef struct {
    logic [167:0] data;
    logic         lst;
  } mesh_beat_t;

  localparam int NUM_FIELDS = 11;
  localparam int FIELD_W [NUM_FIELDS] = '{17, 17, 17, 16, 16, 16, 8, 8, 16, 16, 16};
  localparam string FIELD_NAME [NUM_FIELDS] = '{"pos_x", "pos_y", "pos_z", "nrm_x",
    "nrm_y", "nrm_z", "tan_x", "tan_z", "tex_u", "tex_v", "mesh_index"};
  localparam int ROT_STAGES = 16;
  localparam longint ARC_TURN [ROT_STAGES] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

  mesh_beat_t  beats_due[$];
  logic [15:0] radius_q;
  logic [8:0]  slices_q;

  assign beats_pending = beats_due.size();

  function automatic longint sat_range(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Sine and cosine of a 32-bit phase, Q1.15, via the quadrant-reduced CORDIC.
  function automatic void rotate(input logic [31:0] phase, output longint sn,
                                 output longint cs);
    logic [31:0] shifted;
    logic [1:0]  quad;
    longint x, y, z, dx, dy;
    shifted = phase + 32'h20000000;
    quad = shifted[31:30];
    z = longint'({2'b00, shifted[29:0]}) - 64'sh20000000;
    x = 652032874;
    y = 0;
    for (int k = 0; k < ROT_STAGES; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARC_TURN[k];
      end else begin
        x += dx; y -= dy; z += ARC_TURN[k];
      end
    end
    x = sat_range((x + 16384) >>> 15, -32767, 32767);
    y = sat_range((y + 16384) >>> 15, -32767, 32767);
    case (quad)
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  function automatic logic [7:0] tangent_byte(input longint t);
    return 8'(sat_range((255 * (32768 - t) + 32768) >>> 16, 0, 255));
  endfunction

  // Works out the results of one request and queues them.
  task automatic predict_request(input logic quad_req, input logic [7:0] col,
                                 input logic [7:0] row);
    longint unsigned s, n, i, j, p;
    longint su, cu, sv, cv, nx, ny, nz, tx, tz, r;
    logic [31:0] ph_u, ph_v;
    longint unsigned corner [6];
    mesh_beat_t b;
    s = slices_q < 2 ? 2 : (slices_q > 256 ? 256 : slices_q);
    n = s - 1;
    if (quad_req) begin
      i = col > n - 1 ? n - 1 : col;
      j = row > n - 1 ? n - 1 : row;
      p = i * s + j;
      corner = '{p, p + s, p + s + 1, p, p + s + 1, p + 1};
      for (int k = 0; k < 6; k++) begin
        b.data = '0;
        b.data[162:147] = corner[k][15:0];
        b.lst = (k == 5);
        beats_due.insert(beats_due.size(), b);
      end
    end else begin
      i = col > n ? n : col;
      j = row > n ? n : row;
      ph_u = 32'(((i << 32) + n / 2) / n);
      ph_v = 32'(((j << 31) + n / 2) / n);
      rotate(ph_u, su, cu);
      rotate(ph_v, sv, cv);
      nx = (sv * cu + 16384) >>> 15;
      ny = -cv;
      nz = -((sv * su + 16384) >>> 15);
      // Away from the poles the tangent is the unit longitude direction.
      if (sv > 32) begin
        tx = -su; tz = -cu;
      end else if (sv < -32) begin
        tx = su; tz = cu;
      end else begin
        tx = nz; tz = -nx;
      end
      r = radius_q;
      b.data = '0;
      b.data[16:0]    = 17'((r * nx + 16384) >>> 15);
      b.data[33:17]   = 17'((r * ny + 16384) >>> 15);
      b.data[50:34]   = 17'((r * nz + 16384) >>> 15);
      b.data[66:51]   = 16'(nx);
      b.data[82:67]   = 16'(ny);
      b.data[98:83]   = 16'(nz);
      b.data[106:99]  = tangent_byte(tx);
      b.data[114:107] = tangent_byte(tz);
      b.data[130:115] = 16'((i * 32768 + n / 2) / n);
      b.data[146:131] = 16'((j * 32768 + n / 2) / n);
      b.lst = 1'b1;
      beats_due.insert(beats_due.size(), b);
    end
  endtask

  always @(posedge clk) begin
    mesh_beat_t   want;
    int           off;
    int           errs;
    logic [167:0] mask;
    if (rst) begin
      radius_q   <= 16'd256;
      slices_q   <= 9'd16;
      fail_count <= 0;
      beats_due.delete();
    end else begin
      errs = 0;
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SLICES) slices_q <= pwdata[8:0];
        else radius_q <= pwdata[15:0];
      end
      if (s_tvalid && s_tready) predict_request(s_tuser[0], s_tdata[7:0], s_tdata[15:8]);
      if (m_tvalid && m_tready) begin
        if (beats_due.size() == 0) begin
          $error("result transfer with nothing expected: tdata %h", m_tdata);
          errs++;
        end else begin
          want = beats_due.pop_front();
          off = 0;
          for (int f = 0; f < NUM_FIELDS; f++) begin
            mask = (168'd1 << FIELD_W[f]) - 1;
            if (((want.data >> off) & mask) !== ((m_tdata >> off) & mask)) begin
              $error("%s: expected %h, got %h", FIELD_NAME[f], (want.data >> off) & mask,
                     (m_tdata >> off) & mask);
              errs++;
            end
            off += FIELD_W[f];
          end
          if (want.lst !== m_tlast) begin
            $error("last: expected %b, got %b", want.lst, m_tlast);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

FILE: bench/tb_uv_sphere_mesh_generator_unit.sv
// Testbench top of the UV-sphere mesh generator: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module tb_uv_sphere_mesh_generator_unit;
  import usmg_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // col [7:0], row [15:8]
  logic [15:0]  s_tdata = '0;
  // action [0]
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tan_x, tan_z, tex_u, tex_v,
  // mesh_index, zero fill, from bit 0 upwards
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic         m_tlast;
  int           fail_count, beats_pending;

  localparam logic ACT_VERTEX = 1'b0;
  localparam logic ACT_QUAD   = 1'b1;

  // Burst state of the sender and the slice count as the block will see it.
  int burst_left = 0;
  int eff_slices = 16;

  always #6 clk = ~clk;

  uv_sphere_mesh_generator_unit dut (.*);

  usmg_checker checker_i (.*);

  // Write one register through a setup and an access cycle, then update the local view
  // of the slice count so random indices can be aimed at the valid range.
  task automatic reg_write(input logic reg_sel, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {reg_sel, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (reg_sel == REG_SLICES)
      eff_slices = value[8:0] < 2 ? 2 : (value[8:0] > 256 ? 256 : value[8:0]);
  endtask

  // Hand one request over. Between bursts tvalid drops for a random gap; within a
  // burst it stays high from one transfer to the next.
  task automatic send_request(input logic act, input logic [7:0] col, input logic [7:0] row);
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tuser = act;
    s_tdata = {row, col};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Random request: mostly indices inside the mesh, sometimes anything the field allows.
  task automatic send_random;
    logic [7:0] c, r;
    c = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, eff_slices - 1)) : 8'($urandom);
    r = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, eff_slices - 1)) : 8'($urandom);
    send_request(1'($urandom), c, r);
  endtask

  // Registers are changed only once every outstanding result has come back.
  task automatic drain;
    s_tvalid = 1'b0;
    while (beats_pending != 0) @(negedge clk);
  endtask

  // The receiver switches between always-ready, random and mostly-stalled stretches.
  int ready_mode = 0, ready_left = 0;
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_left <= $urandom_range(5, 60);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset setting (radius 1.0, 16 slices): corners, poles, clamped indices, quads.
    send_request(ACT_VERTEX, 8'd0, 8'd0);
    send_request(ACT_VERTEX, 8'd15, 8'd15);
    send_request(ACT_VERTEX, 8'd255, 8'd255);
    send_request(ACT_VERTEX, 8'd4, 8'd8);
    send_request(ACT_VERTEX, 8'd12, 8'd3);
    send_request(ACT_VERTEX, 8'd7, 8'd0);
    send_request(ACT_VERTEX, 8'd3, 8'd15);
    send_request(ACT_QUAD, 8'd0, 8'd0);
    send_request(ACT_QUAD, 8'd14, 8'd14);
    send_request(ACT_QUAD, 8'd255, 8'd255);
    drain();

    // Largest radius and the largest mesh.
    reg_write(REG_RADIUS, 32'hFFFF);
    reg_write(REG_SLICES, 32'd256);
    send_request(ACT_VERTEX, 8'd255, 8'd255);
    send_request(ACT_VERTEX, 8'd128, 8'd128);
    send_request(ACT_VERTEX, 8'd64, 8'd1);
    send_request(ACT_QUAD, 8'd254, 8'd254);
    send_request(ACT_QUAD, 8'd255, 8'd0);
    drain();

    // Zero radius and the smallest mesh.
    reg_write(REG_RADIUS, 32'd0);
    reg_write(REG_SLICES, 32'd2);
    send_request(ACT_VERTEX, 8'd0, 8'd0);
    send_request(ACT_VERTEX, 8'd1, 8'd1);
    send_request(ACT_VERTEX, 8'd255, 8'd0);
    send_request(ACT_QUAD, 8'd0, 8'd0);
    send_request(ACT_QUAD, 8'd255, 8'd255);
    drain();

    // Random phases, including slice counts below two and above the maximum.
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(REG_RADIUS, (ph == 5) ? 32'hFFFF : 32'($urandom_range(0, 65535)));
      case (ph)
        0: reg_write(REG_SLICES, 32'd0);
        1: reg_write(REG_SLICES, 32'd1);
        2: reg_write(REG_SLICES, 32'd300);
        3: reg_write(REG_SLICES, 32'd511);
        default: reg_write(REG_SLICES, 32'($urandom_range(2, 256)));
      endcase
      repeat (20) send_random();
      drain();
    end

    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
